// ===== rtl/core/pws_pkg.sv =====
`default_nettype none

package pws_pkg;

    // Field and datapath widths.
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int AXIS_W       = 12;
    localparam int MUL_B_W      = DIFF_W;
    localparam int K_W          = 2 * DIFF_W + 1;
    localparam int PROD_W       = K_W + MUL_B_W;
    localparam int TERM_W       = 48;
    localparam int SUM_W        = 64;

    // Vertex counting.
    localparam int MAX_VERTICES = 4096;
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int MIN_VERTICES = 3;

    // Stream packing.
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z = 2'd2;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [K_W-1:0]    mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;

endpackage

`default_nettype wire

// ===== rtl/core/pws_mul.sv =====
`default_nettype none

// Shared signed multiplier with a registered product.
module pws_mul
    import pws_pkg::*;
(
    input  wire logic   clk,
    input  wire mul_a_t a,
    input  wire mul_b_t b,
    output prod_t       p
);

    prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pws_acc.sv =====
`default_nettype none

// Saturating 64-bit signed area accumulator.
module pws_acc
    import pws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  clear,
    input  wire logic  add_en,
    input  wire term_t term,
    output logic       sum_neg,
    output logic       sat_hit
);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic        [SUM_W:0]   wide;

    always_comb
    begin
        wide     = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W + 1 - TERM_W){term[TERM_W-1]}}, term};
        sat_hit  = 1'b0;
        sum_next = sum_reg;
        if (add_en)
        begin
            if (wide[SUM_W] != wide[SUM_W-1])
            begin
                sat_hit = 1'b1;
                // The sign of the wide sum tells which limit was crossed.
                sum_next = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                sum_next = wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (clear)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_neg = sum_reg[SUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/polygon_winding_sign_top.sv =====
`default_nettype none

// Polygon orientation test. Vertices of one closed polygon arrive as 16-bit
// signed 3D points on the slave stream, the final vertex marked by tlast.
// The block sums the projected signed area of the triangle fan rooted at the
// first vertex onto the programmable axis (a zero axis means plus Z) in a
// saturating 64-bit accumulator, and after the final vertex it sends one
// transfer on the master stream with the winding sign and two status flags.
// Throughput is set by a single shared multiplier that does the nine products
// of each fan triangle one after the other: the first two vertices of a
// polygon only pass through accept and store, every later vertex passes through
// accept, coordinate differences, ten multiplier slots and accumulate, and the
// final vertex then loads the result register, waiting while that register
// still holds an untaken result. The slave side is not ready while a vertex
// is in work. Axis registers may only be written while the block is idle.
module polygon_winding_sign_top
    import pws_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [AXIS_W-1:0]     cfg_data,

    // Vertex stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
    input  wire logic                  s_axis_tlast,   // last_vertex

    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata    // negative_winding,
                                                       // too_few_vertices,
                                                       // area_saturated, zero pad
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_CALC,
        S_FINISH,
        S_EMIT
    } state_t;

    // Multiplier slots. Each slot names the product issued in it; the product
    // of the previous slot is consumed in the same cycle.
    typedef enum logic [3:0] {
        MS_AYBZ,
        MS_AZBY,
        MS_AZBX,
        MS_AXBZ,
        MS_AXBY,
        MS_AYBX,
        MS_KXNX,
        MS_KYNY,
        MS_KZNZ,
        MS_DRAIN
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic signed [AXIS_W-1:0]  axis_x_reg, axis_y_reg, axis_z_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, first_z_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic                      last_reg;
    logic        [COUNT_W-1:0] count_reg;
    logic                      saturated_reg;

    // Edge vectors of the current fan triangle.
    diff_t ax_reg, ay_reg, az_reg;
    diff_t bx_reg, by_reg, bz_reg;

    // Cross product components and the projected term.
    mul_a_t kx_reg, ky_reg, kz_reg;
    term_t  term_reg;

    logic                      m_valid_reg;
    logic [OUT_DATA_W-1:0]     m_data_reg;

    mul_a_t mul_a;
    mul_b_t mul_b;
    prod_t  prod;

    logic   axis_zero;
    mul_b_t nx, ny, nz;

    logic   acc_add;
    logic   acc_clear;
    logic   sum_neg;
    logic   sat_hit;

    logic   in_fire;
    logic   emit_fire;
    logic   has_triangle;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_axis_tready);
    assign has_triangle = (count_reg >= COUNT_W'(2));

    assign acc_add   = (state_reg == S_FINISH) && has_triangle;
    assign acc_clear = emit_fire;

    // A zero axis stands for plus Z.
    assign axis_zero = (axis_x_reg == '0) && (axis_y_reg == '0) && (axis_z_reg == '0);
    assign nx = mul_b_t'(axis_x_reg);
    assign ny = mul_b_t'(axis_y_reg);
    assign nz = axis_zero ? mul_b_t'(1) : mul_b_t'(axis_z_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = mul_a_t'(ay_reg);
        mul_b = bz_reg;
        case (step_reg)
            MS_AYBZ:
            begin
                mul_a = mul_a_t'(ay_reg);
                mul_b = bz_reg;
            end
            MS_AZBY:
            begin
                mul_a = mul_a_t'(az_reg);
                mul_b = by_reg;
            end
            MS_AZBX:
            begin
                mul_a = mul_a_t'(az_reg);
                mul_b = bx_reg;
            end
            MS_AXBZ:
            begin
                mul_a = mul_a_t'(ax_reg);
                mul_b = bz_reg;
            end
            MS_AXBY:
            begin
                mul_a = mul_a_t'(ax_reg);
                mul_b = by_reg;
            end
            MS_AYBX:
            begin
                mul_a = mul_a_t'(ay_reg);
                mul_b = bx_reg;
            end
            MS_KXNX:
            begin
                mul_a = kx_reg;
                mul_b = nx;
            end
            MS_KYNY:
            begin
                mul_a = ky_reg;
                mul_b = ny;
            end
            MS_KZNZ:
            begin
                mul_a = kz_reg;
                mul_b = nz;
            end
            default:
            begin
                mul_a = kz_reg;
                mul_b = nz;
            end
        endcase
    end

    pws_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    pws_acc u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (acc_clear),
        .add_en  (acc_add),
        .term    (term_reg),
        .sum_neg (sum_neg),
        .sat_hit (sat_hit)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            axis_z_reg <= AXIS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AXIS_X: axis_x_reg <= cfg_data;
                CFG_AXIS_Y: axis_y_reg <= cfg_data;
                CFG_AXIS_Z: axis_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Datapath registers that need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_x_reg <= s_axis_tdata[COORD_W-1:0];
            cur_y_reg <= s_axis_tdata[2*COORD_W-1:COORD_W];
            cur_z_reg <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            last_reg  <= s_axis_tlast;
        end

        if (state_reg == S_DIFF)
        begin
            ax_reg <= diff_t'(prev_x_reg) - diff_t'(first_x_reg);
            ay_reg <= diff_t'(prev_y_reg) - diff_t'(first_y_reg);
            az_reg <= diff_t'(prev_z_reg) - diff_t'(first_z_reg);
            bx_reg <= diff_t'(cur_x_reg) - diff_t'(first_x_reg);
            by_reg <= diff_t'(cur_y_reg) - diff_t'(first_y_reg);
            bz_reg <= diff_t'(cur_z_reg) - diff_t'(first_z_reg);
        end

        if (state_reg == S_CALC)
        begin
            // Consume the product issued in the previous slot.
            case (step_reg)
                MS_AZBY:  kx_reg   <= prod[K_W-1:0];
                MS_AZBX:  kx_reg   <= kx_reg - prod[K_W-1:0];
                MS_AXBZ:  ky_reg   <= prod[K_W-1:0];
                MS_AXBY:  ky_reg   <= ky_reg - prod[K_W-1:0];
                MS_AYBX:  kz_reg   <= prod[K_W-1:0];
                MS_KXNX:  kz_reg   <= kz_reg - prod[K_W-1:0];
                MS_KYNY:  term_reg <= prod[TERM_W-1:0];
                MS_KZNZ:  term_reg <= term_reg + prod[TERM_W-1:0];
                MS_DRAIN: term_reg <= term_reg + prod[TERM_W-1:0];
                default:  ;
            endcase
        end
    end

    // Sequencer, polygon state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= MS_AYBZ;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            first_z_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            count_reg     <= '0;
            saturated_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && !emit_fire)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= has_triangle ? S_DIFF : S_FINISH;
                    end
                end
                S_DIFF:
                begin
                    step_reg  <= MS_AYBZ;
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (step_reg == MS_DRAIN)
                    begin
                        step_reg  <= MS_AYBZ;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_t'(step_reg + 4'd1);
                    end
                end
                S_FINISH:
                begin
                    if (count_reg == '0)
                    begin
                        first_x_reg <= cur_x_reg;
                        first_y_reg <= cur_y_reg;
                        first_z_reg <= cur_z_reg;
                    end
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    prev_z_reg <= cur_z_reg;

                    // The count stops at its limit; each vertex past it flags
                    // saturation but still contributes its fan term.
                    if (count_reg < COUNT_W'(MAX_VERTICES))
                    begin
                        count_reg     <= count_reg + COUNT_W'(1);
                        saturated_reg <= saturated_reg | sat_hit;
                    end
                    else
                    begin
                        saturated_reg <= 1'b1;
                    end

                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{(OUT_DATA_W-3){1'b0}},
                                        saturated_reg,
                                        (count_reg < COUNT_W'(MIN_VERTICES)),
                                        (count_reg >= COUNT_W'(MIN_VERTICES)) && sum_neg};
                        first_x_reg   <= '0;
                        first_y_reg   <= '0;
                        first_z_reg   <= '0;
                        prev_x_reg    <= '0;
                        prev_y_reg    <= '0;
                        prev_z_reg    <= '0;
                        count_reg     <= '0;
                        saturated_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pws_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 3_000_000;

    // Idle cycles that let the block finish a fan vertex and load the result
    // register, so that it settles completely.
    localparam int SETTLE_CYCLES = 40;

    // Stimulus sizes.
    localparam int RANDOM_ITEMS  = 1620;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 40;

    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    // One result transfer as it sits on m_axis_tdata, lowest bit last.
    typedef struct packed {
        logic [OUT_DATA_W-4:0] pad;
        logic                  sat;
        logic                  few;
        logic                  neg;
    } winding_word_t;

    localparam winding_word_t WORD_TOO_FEW  = '{pad: '0, sat: 1'b0, few: 1'b1, neg: 1'b0};
    localparam winding_word_t WORD_POSITIVE = '{pad: '0, sat: 1'b0, few: 1'b0, neg: 1'b0};
    localparam winding_word_t WORD_NEGATIVE = '{pad: '0, sat: 1'b0, few: 1'b0, neg: 1'b1};

    // How the vertices of a random polygon are spread out.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NEAR,
        SPREAD_CORNERS,
        SPREAD_LINE
    } spread_t;

    // One row of the directed stimulus. When typed is set, want holds the
    // result that the closing vertex must produce; otherwise the fan-area
    // predictor supplies it.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        bit                        closing;
        bit                        typed;
        winding_word_t             want;
    } vertex_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [AXIS_W-1:0]    cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;    // pos_x, pos_y, pos_z
    logic                 s_axis_tlast;    // last_vertex
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // negative_winding, too_few_vertices,
                                           // area_saturated, zero pad

    polygon_winding_sign_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the axis registers and of the polygon being summed. The
    // predictor below folds in every vertex at the moment its transfer is
    // accepted.
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] prev_z;
    int unsigned               vertex_total;
    longint                    area_acc;
    bit                        area_sat;

    // Winding results still owed by the block, oldest first.
    winding_word_t owed_windings[$];
    vertex_row_t   directed_rows[$];

    // Test bookkeeping.
    int  mismatches      = 0;
    int  vertices_sent   = 0;
    int  polygons_closed = 0;
    int  windings_seen   = 0;
    int  axis_settings   = 0;
    int  cycles          = 0;
    bit  steady_flow     = 1'b0;
    bit  hold_results    = 1'b0;

    // Prints one line per mismatch (up to a limit) and counts all of them.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                     $realtime, what, got, want, windings_seen);
        mismatches++;
    endtask

    function automatic void clear_polygon();
        first_x = '0;
        first_y = '0;
        first_z = '0;
        prev_x = '0;
        prev_y = '0;
        prev_z = '0;
        vertex_total = 0;
        area_acc = 0;
        area_sat = 1'b0;
    endfunction

    // Adds one vertex to the current polygon. From the third vertex on, each
    // vertex closes a triangle of the fan rooted at the first vertex, and the
    // triangle's cross product projected on the axis goes into a saturating
    // 64-bit sum. Returns 1 with the winding word when the vertex closes the
    // polygon.
    function automatic bit fold_vertex(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic signed [COORD_W-1:0] z,
                                       input bit closing,
                                       output winding_word_t res);
        longint ux, uy, uz, vx, vy, vz;
        longint cx, cy, cz, nx, ny, nz, term;
        res = '0;
        if (vertex_total == 0) begin
            first_x = x;
            first_y = y;
            first_z = z;
        end else if (vertex_total >= 2) begin
            ux = longint'(prev_x) - longint'(first_x);
            uy = longint'(prev_y) - longint'(first_y);
            uz = longint'(prev_z) - longint'(first_z);
            vx = longint'(x) - longint'(first_x);
            vy = longint'(y) - longint'(first_y);
            vz = longint'(z) - longint'(first_z);
            cx = uy * vz - uz * vy;
            cy = uz * vx - ux * vz;
            cz = ux * vy - uy * vx;
            nx = longint'(axis_x);
            ny = longint'(axis_y);
            nz = longint'(axis_z);
            // An all-zero axis stands for plus Z.
            if (nx == 0 && ny == 0 && nz == 0)
                nz = 1;
            term = cx * nx + cy * ny + cz * nz;
            if (term > 0 && area_acc > SUM_MAX - term) begin
                area_acc = SUM_MAX;
                area_sat = 1'b1;
            end else if (term < 0 && area_acc < SUM_MIN - term) begin
                area_acc = SUM_MIN;
                area_sat = 1'b1;
            end else begin
                area_acc += term;
            end
        end
        // The count sticks at its limit; later vertices still add their term.
        if (vertex_total < MAX_VERTICES)
            vertex_total++;
        else
            area_sat = 1'b1;
        prev_x = x;
        prev_y = y;
        prev_z = z;
        if (!closing)
            return 1'b0;
        res.few = (vertex_total < MIN_VERTICES);
        res.neg = !res.few && (area_acc < 0);
        res.sat = area_sat;
        clear_polygon();
        return 1'b1;
    endfunction

    // Gap before a vertex: mostly none, sometimes short, rarely long.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Length of a receiver stall: mostly short, a few long.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one vertex and holds it until the block takes it. tvalid stays
    // high across back-to-back transfers and is lowered only for a real gap.
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input bit closing,
                               input bit typed = 1'b0,
                               input winding_word_t want = '0);
        winding_word_t res;
        int gap;
        gap = steady_flow ? 0 : sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        s_axis_tlast <= closing;
        do @(posedge clk); while (!s_axis_tready);
        vertices_sent++;
        if (fold_vertex(x, y, z, closing, res)) begin
            owed_windings.push_back(typed ? want : res);
            polygons_closed++;
        end
    endtask

    // Stops offering vertices and waits for every owed result to arrive.
    task automatic await_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (owed_windings.size() != 0);
    endtask

    // Brings the block to idle, including any vertex still in work.
    task automatic drain_results();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three axis registers on consecutive edges; only called
    // while the block is idle.
    task automatic set_axis(input logic signed [AXIS_W-1:0] nx,
                            input logic signed [AXIS_W-1:0] ny,
                            input logic signed [AXIS_W-1:0] nz);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_AXIS_X;
        cfg_data <= nx;
        @(posedge clk);
        cfg_index <= CFG_AXIS_Y;
        cfg_data <= ny;
        @(posedge clk);
        cfg_index <= CFG_AXIS_Z;
        cfg_data <= nz;
        @(posedge clk);
        cfg_we <= 1'b0;
        axis_x = nx;
        axis_y = ny;
        axis_z = nz;
        axis_settings++;
    endtask

    function automatic logic signed [AXIS_W-1:0] random_axis();
        if ($urandom_range(0, 5) == 0)
            return '0;
        return AXIS_W'($urandom);
    endfunction

    // Coordinates at and next to the ends of the 16-bit range and around zero.
    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 6))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sh7FFE;
            default: return 16'sh7FFF;
        endcase
    endfunction

    function automatic int polygon_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 1;
        if (r < 15)
            return 2;
        if (r < 80)
            return $urandom_range(3, 6);
        if (r < 95)
            return $urandom_range(7, 16);
        return $urandom_range(17, 40);
    endfunction

    function automatic spread_t pick_spread();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SPREAD_FULL;
        if (r < 70)
            return SPREAD_NEAR;
        if (r < 85)
            return SPREAD_CORNERS;
        return SPREAD_LINE;
    endfunction

    // Sends one whole polygon of n vertices, the last one marked by tlast.
    // SPREAD_LINE walks a straight line, so its fan area is zero unless the
    // coordinates wrap.
    task automatic send_polygon(input int n, input spread_t spread);
        logic signed [COORD_W-1:0] bx, by, bz, dx, dy, dz, x, y, z;
        bx = COORD_W'($urandom);
        by = COORD_W'($urandom);
        bz = COORD_W'($urandom);
        dx = COORD_W'(int'($urandom_range(0, 20)) - 10);
        dy = COORD_W'(int'($urandom_range(0, 20)) - 10);
        dz = COORD_W'(int'($urandom_range(0, 20)) - 10);
        for (int k = 0; k < n; k++) begin
            case (spread)
                SPREAD_FULL: begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                    z = COORD_W'($urandom);
                end
                SPREAD_NEAR: begin
                    x = COORD_W'(int'(bx) + int'($urandom_range(0, 600)) - 300);
                    y = COORD_W'(int'(by) + int'($urandom_range(0, 600)) - 300);
                    z = COORD_W'(int'(bz) + int'($urandom_range(0, 600)) - 300);
                end
                SPREAD_CORNERS: begin
                    x = corner_coord();
                    y = corner_coord();
                    z = corner_coord();
                end
                default: begin
                    x = COORD_W'(int'(bx) + k * int'(dx));
                    y = COORD_W'(int'(by) + k * int'(dy));
                    z = COORD_W'(int'(bz) + k * int'(dz));
                end
            endcase
            send_vertex(x, y, z, k == n - 1);
        end
    endtask

    task automatic add_row(input int x, input int y, input int z, input bit closing,
                           input bit typed = 1'b0, input winding_word_t want = '0);
        vertex_row_t row;
        row.x = COORD_W'(x);
        row.y = COORD_W'(y);
        row.z = COORD_W'(z);
        row.closing = closing;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // Compares one result transfer with the oldest owed winding.
    task automatic check_winding(input winding_word_t got);
        winding_word_t want;
        if (owed_windings.size() == 0) begin
            report_mismatch("result with nothing owed", int'(got), 0);
            return;
        end
        want = owed_windings.pop_front();
        windings_seen++;
        if (got.neg !== want.neg)
            report_mismatch("negative_winding", int'(got.neg), int'(want.neg));
        if (got.few !== want.few)
            report_mismatch("too_few_vertices", int'(got.few), int'(want.few));
        if (got.sat !== want.sat)
            report_mismatch("area_saturated", int'(got.sat), int'(want.sat));
        if (got.pad !== want.pad)
            report_mismatch("tdata padding", int'(got.pad), int'(want.pad));
    endtask

    // Every result transfer is checked at the edge that completes it.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_winding(m_axis_tdata);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results still owed",
                     $realtime, owed_windings.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side. It alternates ready runs with stalls, stays ready during
    // steady stretches, and on request holds off for a long count of its own
    // so that the block's result register fills and its input stalls.
    initial begin : result_sink
        int run;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_results) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end else if (steady_flow || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                run = steady_flow ? 1 : $urandom_range(1, 8);
                repeat (run) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (stall_len()) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        int random_start;
        bit pressure_done;
        pressure_done = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_AXIS_X;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        axis_x = '0;
        axis_y = '0;
        axis_z = AXIS_W'(1);
        clear_polygon();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed polygons under the reset axis (plus Z). Counter-clockwise
        // seen from plus Z is positive, clockwise is negative, and a flat or
        // repeated-point polygon has zero area, which does not count as
        // negative.
        add_row(0, 0, 0, 1'b1, 1'b1, WORD_TOO_FEW);               // lone vertex
        add_row(32767, 32767, 32767, 1'b0);                       // two vertices
        add_row(-32768, -32768, -32768, 1'b1, 1'b1, WORD_TOO_FEW);
        add_row(0, 0, 0, 1'b0);                                   // counter-clockwise
        add_row(100, 0, 0, 1'b0);
        add_row(0, 100, 0, 1'b1, 1'b1, WORD_POSITIVE);
        add_row(0, 0, 0, 1'b0);                                   // clockwise
        add_row(0, 100, 0, 1'b0);
        add_row(100, 0, 0, 1'b1, 1'b1, WORD_NEGATIVE);
        add_row(0, 0, 0, 1'b0);                                   // collinear
        add_row(1, 1, 1, 1'b0);
        add_row(2, 2, 2, 1'b1, 1'b1, WORD_POSITIVE);
        add_row(-32768, -32768, -32768, 1'b0);                    // widest differences
        add_row(32767, -32768, 32767, 1'b0);
        add_row(-32768, 32767, -32768, 1'b1);
        add_row(-32768, -32768, 0, 1'b0);                         // full-range square
        add_row(-32768, 32767, 0, 1'b0);
        add_row(32767, 32767, 0, 1'b0);
        add_row(32767, -32768, 0, 1'b1);
        add_row(5, -7, 9, 1'b0);                                  // one repeated point
        add_row(5, -7, 9, 1'b0);
        add_row(5, -7, 9, 1'b1, 1'b1, WORD_POSITIVE);
        foreach (directed_rows[i])
            send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                        directed_rows[i].closing, directed_rows[i].typed,
                        directed_rows[i].want);
        drain_results();

        // Random polygons in phases, each under its own axis. The first
        // settings are the extremes: an all-zero axis, all-negative and
        // all-positive full scale, minus Z, and mixed ends.
        random_start = vertices_sent;
        for (phase = 0; vertices_sent - random_start < RANDOM_ITEMS; phase++) begin
            case (phase)
                0: set_axis(12'sd0, 12'sd0, 12'sd0);
                1: set_axis(-12'sd2048, -12'sd2048, -12'sd2048);
                2: set_axis(12'sd2047, 12'sd2047, 12'sd2047);
                3: set_axis(12'sd0, 12'sd0, -12'sd1);
                4: set_axis(12'sd2047, -12'sd2048, 12'sd0);
                default: set_axis(random_axis(), random_axis(), random_axis());
            endcase
            steady_flow = (phase % 4 == 3);
            phase_end = vertices_sent + PHASE_ITEMS;
            while (vertices_sent < phase_end &&
                   vertices_sent - random_start < RANDOM_ITEMS) begin
                if (phase == 1 && !pressure_done) begin
                    // Results pile up while the sink holds off, so the block
                    // has to stop taking vertices until it lets go.
                    hold_results = 1'b1;
                    repeat (8) send_polygon(3, SPREAD_NEAR);
                    pressure_done = 1'b1;
                end
                send_polygon(polygon_len(), pick_spread());
                // Now and then the sender waits for the block to catch up.
                if ($urandom_range(0, 39) == 0)
                    await_results();
            end
            steady_flow = 1'b0;
            drain_results();
        end

        if (owed_windings.size() != 0)
            report_mismatch("results never delivered", 0, owed_windings.size());
        $display("Sent %0d vertices in %0d polygons under %0d axis settings,",
                 vertices_sent, polygons_closed, axis_settings);
        $display("zero, extreme and random axes alike; %0d results compared, %0d mismatches.",
                 windings_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
